/* rtl/core/arset_pkg.sv */
// Shared types and constants for the address range set engine.
package arset_pkg;

  localparam int MAX_RANGES = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_BITS  = 32;

  localparam int FIELD_W = 32;
  localparam int EW      = ADDR_BITS + 1;
  localparam int SUM_W   = ((ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W) + 2;
  localparam int IDX_W   = $clog2(MAX_RANGES);
  localparam int CNT_W   = $clog2(MAX_RANGES + 1);
  localparam int LIM_W   = 6;
  localparam int CMP_W   = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = 1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic {
    ST_DONE = 1'b0,
    ST_FULL = 1'b1
  } result_code_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_MERGE,
    S_CUT
  } back_state_t;

  typedef struct packed {
    op_t           op;
    logic [EW-1:0] lo;
    logic [EW-1:0] hi;
  } req_t;

endpackage

/* rtl/core/arset_front.sv */
// Front end: page rounding and saturation of an incoming request.
module arset_front (
  input  logic                                op,
  input  logic [arset_pkg::FIELD_W-1:0]       base_address,
  input  logic [arset_pkg::FIELD_W-1:0]       byte_length,
  output arset_pkg::req_t                     req
);

  localparam logic [arset_pkg::SUM_W-1:0] PAGE_M1 =
    (arset_pkg::SUM_W'(1) << arset_pkg::PAGE_SHIFT) - arset_pkg::SUM_W'(1);
  localparam logic [arset_pkg::SUM_W-1:0] TOP =
    arset_pkg::SUM_W'(1) << arset_pkg::ADDR_BITS;

  logic [arset_pkg::SUM_W-1:0] lo_raw;
  logic [arset_pkg::SUM_W-1:0] hi_raw;
  logic [arset_pkg::SUM_W-1:0] lo_sat;
  logic [arset_pkg::SUM_W-1:0] hi_sat;

  always_comb begin
    lo_raw = arset_pkg::SUM_W'(base_address) & ~PAGE_M1;
    hi_raw = (arset_pkg::SUM_W'(base_address) + arset_pkg::SUM_W'(byte_length) + PAGE_M1)
             & ~PAGE_M1;
    lo_sat = (lo_raw > TOP) ? TOP : lo_raw;
    hi_sat = (hi_raw > TOP) ? TOP : hi_raw;
    req.op = arset_pkg::op_t'(op);
    req.lo = lo_sat[arset_pkg::EW-1:0];
    req.hi = hi_sat[arset_pkg::EW-1:0];
  end

endmodule

/* rtl/core/arset_queue.sv */
// Two-entry request queue between front end and back end.
module arset_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  arset_pkg::req_t push_req,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop,
  output arset_pkg::req_t pop_req
);

  arset_pkg::req_t               slots [arset_pkg::Q_DEPTH];
  logic [arset_pkg::QP_W-1:0]    wptr;
  logic [arset_pkg::QP_W-1:0]    rptr;
  logic [arset_pkg::QP_W:0]      fill;

  assign full      = (fill == (arset_pkg::QP_W + 1)'(arset_pkg::Q_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_req   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) wptr <= wptr + 1'b1;
      if (pop && pop_valid) rptr <= rptr + 1'b1;
      fill <= fill + (arset_pkg::QP_W + 1)'(push && !full)
                   - (arset_pkg::QP_W + 1)'(pop && pop_valid);
    end
  end

endmodule

/* rtl/core/arset_back.sv */
// Back end: range table and the sequencer that inserts, merges and cuts.
module arset_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  arset_pkg::req_t              q_req,
  output logic                         q_pop,
  input  logic [arset_pkg::LIM_W-1:0]  range_limit,
  output logic                         res_valid,
  output logic                         res_status,
  output logic [arset_pkg::CNT_W-1:0]  count
);

  localparam int EW = arset_pkg::EW;
  localparam int CW = arset_pkg::CNT_W;
  localparam int IW = arset_pkg::IDX_W;

  logic [EW-1:0] ent_s [arset_pkg::MAX_RANGES];
  logic [EW-1:0] ent_e [arset_pkg::MAX_RANGES];

  arset_pkg::back_state_t state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] gi, gi_next;
  logic [CW-1:0] count_next;
  logic [EW-1:0] lo, lo_next, hi, hi_next, cs, cs_next, ce, ce_next;
  logic          res_valid_next, res_status_next;

  logic          wr_s_en, wr_e_en, drop_en;
  logic [IW-1:0] wr_idx;
  logic [EW-1:0] wr_s, wr_e;
  logic [EW-1:0] rs, re;
  logic          room;

  assign rs   = ent_s[idx[IW-1:0]];
  assign re   = ent_e[idx[IW-1:0]];
  assign room = (count < CW'(arset_pkg::MAX_RANGES)) &&
                (arset_pkg::CMP_W'(count) < arset_pkg::CMP_W'(range_limit));

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    gi_next         = gi;
    count_next      = count;
    lo_next         = lo;
    hi_next         = hi;
    cs_next         = cs;
    ce_next         = ce;
    res_valid_next  = 1'b0;
    res_status_next = res_status;
    wr_s_en         = 1'b0;
    wr_e_en         = 1'b0;
    drop_en         = 1'b0;
    wr_idx          = idx[IW-1:0];
    wr_s            = '0;
    wr_e            = '0;
    q_pop           = 1'b0;
    case (state)
      arset_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          lo_next  = q_req.lo;
          hi_next  = q_req.hi;
          idx_next = '0;
          if (q_req.op == arset_pkg::OP_REMOVE) begin
            state_next = arset_pkg::S_CUT;
          end else if (q_req.hi <= q_req.lo) begin
            res_valid_next  = 1'b1;
            res_status_next = arset_pkg::ST_DONE;
          end else begin
            state_next = arset_pkg::S_ADD;
          end
        end
      end
      arset_pkg::S_ADD: begin
        if (idx == count) begin
          res_valid_next = 1'b1;
          state_next     = arset_pkg::S_IDLE;
          if (room) begin
            wr_s_en         = 1'b1;
            wr_e_en         = 1'b1;
            wr_idx          = count[IW-1:0];
            wr_s            = lo;
            wr_e            = hi;
            count_next      = count + 1'b1;
            res_status_next = arset_pkg::ST_DONE;
          end else begin
            res_status_next = arset_pkg::ST_FULL;
          end
        end else if (hi < rs || lo > re) begin
          idx_next = idx + 1'b1;
        end else if (lo >= rs && hi <= re) begin
          res_valid_next  = 1'b1;
          res_status_next = arset_pkg::ST_DONE;
          state_next      = arset_pkg::S_IDLE;
        end else begin
          cs_next    = (lo < rs) ? lo : rs;
          ce_next    = (hi > re) ? hi : re;
          gi_next    = idx;
          idx_next   = '0;
          state_next = arset_pkg::S_MERGE;
        end
      end
      arset_pkg::S_MERGE: begin
        if (idx == count) begin
          wr_s_en         = 1'b1;
          wr_e_en         = 1'b1;
          wr_idx          = gi[IW-1:0];
          wr_s            = cs;
          wr_e            = ce;
          res_valid_next  = 1'b1;
          res_status_next = arset_pkg::ST_DONE;
          state_next      = arset_pkg::S_IDLE;
        end else if (idx == gi) begin
          idx_next = idx + 1'b1;
        end else if ((cs <= re && re <= ce) || (rs <= ce && re > ce)) begin
          cs_next    = (rs < cs) ? rs : cs;
          ce_next    = (re > ce) ? re : ce;
          drop_en    = 1'b1;
          count_next = count - 1'b1;
          if (idx < gi) gi_next = gi - 1'b1;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      arset_pkg::S_CUT: begin
        if (idx == count) begin
          res_valid_next  = 1'b1;
          res_status_next = arset_pkg::ST_DONE;
          state_next      = arset_pkg::S_IDLE;
        end else if (lo <= rs) begin
          if (hi <= rs) begin
            idx_next = idx + 1'b1;
          end else if (hi >= re) begin
            drop_en    = 1'b1;
            count_next = count - 1'b1;
          end else begin
            wr_s_en  = 1'b1;
            wr_s     = hi;
            idx_next = idx + 1'b1;
          end
        end else if (hi >= re) begin
          if (lo < re) begin
            wr_e_en = 1'b1;
            wr_e    = lo;
          end
          idx_next = idx + 1'b1;
        end else begin
          // cut strictly inside: keep head, re-insert the tail
          wr_e_en    = 1'b1;
          wr_e       = lo;
          lo_next    = hi;
          hi_next    = re;
          idx_next   = '0;
          state_next = arset_pkg::S_ADD;
        end
      end
      default: state_next = arset_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < arset_pkg::MAX_RANGES; k++) begin
      if (drop_en && (IW'(k) >= idx[IW-1:0]) && (k < arset_pkg::MAX_RANGES - 1)) begin
        ent_s[k] <= ent_s[IW'(k + 1)];
        ent_e[k] <= ent_e[IW'(k + 1)];
      end else if (wr_idx == IW'(k)) begin
        if (wr_s_en) ent_s[k] <= wr_s;
        if (wr_e_en) ent_e[k] <= wr_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= arset_pkg::S_IDLE;
      count      <= '0;
      res_valid  <= 1'b0;
      res_status <= arset_pkg::ST_DONE;
      idx        <= '0;
      gi         <= '0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      res_valid  <= res_valid_next;
      res_status <= res_status_next;
      idx        <= idx_next;
      gi         <= gi_next;
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    cs <= cs_next;
    ce <= ce_next;
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(arset_pkg::MAX_RANGES))
    else $error("entry count above table size");

  a_res_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> state == arset_pkg::S_IDLE)
    else $error("result strobe while sequencer busy");

  a_full_nochg: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status) |-> count == $past(count))
    else $error("table full report but count changed");

  a_merge_gi: assert property (@(posedge clk) disable iff (rst)
    state == arset_pkg::S_MERGE |-> gi < count)
    else $error("growing entry index out of table");

endmodule

/* rtl/core/address_range_set_engine_unit.sv */
// Top level of the address range set engine.
// Keeps a table of page-aligned address ranges. A request (start high while busy
// is low) inserts (op 0) or removes (op 1) the range base_address..base_address+byte_length,
// rounded out to the page. Requests pass through a two-entry queue, so busy rises only when
// two requests wait; each finished request shows status and entry_count for one cycle with
// result_valid high, and the receiver cannot stall that strobe. A request is handled by the
// back-end sequencer, which reads one entry a cycle as it sweeps the table entries; a merge
// or split costs a further sweep of the table. The cfg write channel is always ready and
// sets range_limit (reset 32); write it only while no request is pending.
module address_range_set_engine_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op,
  input  logic [arset_pkg::FIELD_W-1:0]       base_address,
  input  logic [arset_pkg::FIELD_W-1:0]       byte_length,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [arset_pkg::LIM_W-1:0]         cfg_data,
  output logic                                result_valid,
  output logic                                status,
  output logic [5:0]                          entry_count
);

  arset_pkg::req_t             front_req;
  arset_pkg::req_t             q_req;
  logic                        q_valid;
  logic                        q_pop;
  logic [arset_pkg::LIM_W-1:0] range_limit;
  logic [arset_pkg::CNT_W-1:0] count;

  // config register, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit <= arset_pkg::LIM_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      range_limit <= cfg_data;
    end
  end

  arset_front u_front (
    .op           (op),
    .base_address (base_address),
    .byte_length  (byte_length),
    .req          (front_req)
  );

  // queue full is the only thing that holds off a new transaction
  arset_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (start),
    .push_req  (front_req),
    .full      (busy),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_req   (q_req)
  );

  arset_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_req       (q_req),
    .q_pop       (q_pop),
    .range_limit (range_limit),
    .res_valid   (result_valid),
    .res_status  (status),
    .count       (count)
  );

  assign entry_count = 6'(count);

endmodule
